// File: hw/rtl/chva_pkg.sv
// Shared constants and types of the circle Hough vote accumulator.
// Used by the channel interfaces, the circle generator and the top level.
// No dependencies.
`default_nettype none

package chva_pkg;

    localparam int ACC_WIDTH_DEF  = 512;
    localparam int ACC_HEIGHT_DEF = 512;
    localparam int MAX_RADIUS_DEF = 64;

    localparam int POS_W    = 9;
    localparam int RADIUS_W = 7;
    localparam int COUNT_W  = 16;
    localparam int CAST_W   = 11;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 7'd38;

    localparam logic KIND_VOTE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        logic busy;
        logic pt_valid;
    } t_gen_status;

endpackage

`default_nettype wire

// File: hw/rtl/chva_in_if.sv
// Input channel of the circle Hough vote accumulator: one vote or read word.
// Depends on chva_pkg for the field widths.
`default_nettype none

interface chva_in_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [chva_pkg::POS_W-1:0]  pos_x;
    logic [chva_pkg::POS_W-1:0]  pos_y;

    modport source (output valid, kind, pos_x, pos_y, input ready);
    modport sink   (input valid, kind, pos_x, pos_y, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/chva_out_if.sv
// Output channel of the circle Hough vote accumulator: one result word.
// Depends on chva_pkg for the field widths.
`default_nettype none

interface chva_out_if;
    logic                          valid;
    logic                          ready;
    logic [chva_pkg::COUNT_W-1:0]  cell_count;
    logic [chva_pkg::CAST_W-1:0]   votes_cast;
    logic                          votes_dropped;

    modport source (output valid, cell_count, votes_cast, votes_dropped, input ready);
    modport sink   (input valid, cell_count, votes_cast, votes_dropped, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/chva_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module chva_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/chva_circle_gen.sv
// Midpoint circle point sequencer: the axis points first, then one shared error update
// per octant step, then its points, one circle point offset per cycle. Offsets are radius +/- x or y.
// Depends on chva_pkg.
`default_nettype none

module chva_circle_gen #(
    parameter int MAX_RADIUS = chva_pkg::MAX_RADIUS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [$clog2(MAX_RADIUS+1)-1:0]   i_radius,
    output chva_pkg::t_gen_status                  o_status,
    output logic      [$clog2(MAX_RADIUS+1):0]     o_ofs_x,
    output logic      [$clog2(MAX_RADIUS+1):0]     o_ofs_y
);

    localparam int XW = $clog2(MAX_RADIUS + 1);
    localparam int OW = XW + 1;
    localparam int EW = XW + 3;

    localparam logic [2:0] AXIS_LAST = 3'd3;
    localparam logic [2:0] HALF_LAST = 3'd3;
    localparam logic [2:0] OCT_LAST  = 3'd7;

    typedef enum logic [1:0] {
        G_IDLE,
        G_AXIS,
        G_STEP,
        G_EMIT
    } t_gen_state;

    t_gen_state            r_state;
    logic [XW-1:0]         r_r;
    logic [XW-1:0]         r_x;
    logic [XW-1:0]         r_y;
    logic signed [EW-1:0]  r_err;
    logic [2:0]            r_k;

    logic [XW-1:0]         n_x;
    logic [XW-1:0]         n_y;
    logic signed [EW-1:0]  n_err;
    logic [OW-1:0]         rad;
    logic [OW-1:0]         rpx;
    logic [OW-1:0]         rmx;
    logic [OW-1:0]         rpy;
    logic [OW-1:0]         rmy;
    logic                  emit_last;

    always_comb begin
        n_y = r_y + XW'(1);
        if (r_err <= 0) begin
            n_x   = r_x;
            n_err = r_err + $signed({2'b00, n_y, 1'b1});
        end else begin
            n_x   = r_x - XW'(1);
            n_err = r_err + $signed({2'b00, n_y, 1'b1}) - $signed({2'b00, n_x, 1'b0});
        end
    end

    always_comb begin
        rad = OW'(r_r);
        rpx = rad + OW'(r_x);
        rmx = rad - OW'(r_x);
        rpy = rad + OW'(r_y);
        rmy = rad - OW'(r_y);
        o_ofs_x = rad;
        o_ofs_y = rad;
        if (r_state == G_AXIS) begin
            case (r_k[1:0])
                2'd0:    begin o_ofs_x = rpx; o_ofs_y = rad; end
                2'd1:    begin o_ofs_x = rad; o_ofs_y = rpx; end
                2'd2:    begin o_ofs_x = rmx; o_ofs_y = rad; end
                default: begin o_ofs_x = rad; o_ofs_y = rmx; end
            endcase
        end else begin
            case (r_k)
                3'd0:    begin o_ofs_x = rpx; o_ofs_y = rpy; end
                3'd1:    begin o_ofs_x = rmx; o_ofs_y = rpy; end
                3'd2:    begin o_ofs_x = rpx; o_ofs_y = rmy; end
                3'd3:    begin o_ofs_x = rmx; o_ofs_y = rmy; end
                3'd4:    begin o_ofs_x = rpy; o_ofs_y = rpx; end
                3'd5:    begin o_ofs_x = rmy; o_ofs_y = rpx; end
                3'd6:    begin o_ofs_x = rpy; o_ofs_y = rmx; end
                default: begin o_ofs_x = rmy; o_ofs_y = rmx; end
            endcase
        end
    end

    assign emit_last = (r_x == r_y) ? (r_k == HALF_LAST) : (r_k == OCT_LAST);

    assign o_status = {(r_state != G_IDLE), ((r_state == G_AXIS) || (r_state == G_EMIT))};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= G_IDLE;
        end else begin
            case (r_state)
                G_IDLE: begin
                    if (i_start) begin
                        r_r     <= i_radius;
                        r_x     <= i_radius;
                        r_y     <= '0;
                        r_err   <= $signed(EW'(1)) - $signed({3'b000, i_radius});
                        r_k     <= '0;
                        r_state <= G_AXIS;
                    end
                end
                G_AXIS: begin
                    if (r_r == '0 || r_k == AXIS_LAST) begin
                        r_state <= G_STEP;
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                G_STEP: begin
                    if (!(r_x > r_y) || (n_x < n_y)) begin
                        r_state <= G_IDLE;
                    end else begin
                        r_x     <= n_x;
                        r_y     <= n_y;
                        r_err   <= n_err;
                        r_k     <= '0;
                        r_state <= G_EMIT;
                    end
                end
                G_EMIT: begin
                    if (emit_last) begin
                        r_state <= G_STEP;
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                default: begin
                    r_state <= G_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/circle_hough_vote_accumulator.sv
// Circle Hough vote accumulator: a 16-bit vote store of ACC_WIDTH x ACC_HEIGHT cells
// with a midpoint-circle vote sequencer and a read-modify-write pipeline.
// Depends on chva_pkg, chva_in_if, chva_out_if, chva_ram and chva_circle_gen.
//
// Usage: i_in carries one word per item. kind selects a vote (the edge pixel at
// pos_x, pos_y casts one vote on each point of the circle of the configured radius,
// centred radius pixels right and down) or a read of the cell at column pos_x,
// row pos_y. o_out returns exactly one result word per item: cell_count for a read,
// votes_cast and votes_dropped for a vote. The radius is written through
// i_cfg_wr_en and i_cfg_wr_data while no item is in flight; values above
// MAX_RADIUS act as MAX_RADIUS.
// One item is processed at a time and i_in.ready stays low meanwhile. A vote emits
// its circle points in turn (4 axis points, or 1 at radius 0, then 8 or 4 per
// octant step, with one error update per octant step); each point inside the store
// is read and written back incremented. A read fetches its one cell through the same
// stages. The next word can be taken in the same cycle as the result is raised.
// After reset the store is cleared one cell per cycle, all ACC_WIDTH * ACC_HEIGHT
// cells (262144 by default), before the first item is taken. A finished result
// is held in the output register until taken; a new item may be accepted while it
// waits, but its own result waits for the register to free.
`default_nettype none

module circle_hough_vote_accumulator #(
    parameter int ACC_WIDTH  = chva_pkg::ACC_WIDTH_DEF,
    parameter int ACC_HEIGHT = chva_pkg::ACC_HEIGHT_DEF,
    parameter int MAX_RADIUS = chva_pkg::MAX_RADIUS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [chva_pkg::RADIUS_W-1:0]   i_cfg_wr_data,
    chva_in_if.sink                              i_in,
    chva_out_if.source                           o_out
);

    localparam int XW    = $clog2(MAX_RADIUS + 1);
    localparam int OW    = XW + 1;
    localparam int CW    = ((OW > chva_pkg::POS_W) ? OW : chva_pkg::POS_W) + 1;
    localparam int COLW  = $clog2(ACC_WIDTH);
    localparam int ROWW  = $clog2(ACC_HEIGHT);
    localparam int DEPTH = ACC_WIDTH * ACC_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_VOTE,
        S_READ,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state                           r_state;
    logic [chva_pkg::RADIUS_W-1:0]    r_radius;
    logic [AW-1:0]                    r_clr_addr;
    logic [chva_pkg::POS_W-1:0]       r_px;
    logic [chva_pkg::POS_W-1:0]       r_py;
    logic [chva_pkg::CAST_W-1:0]      r_hits;
    logic                             r_miss;
    logic [chva_pkg::COUNT_W-1:0]     r_cell;
    logic                             r_s1_valid;
    logic                             r_s1_read;
    logic [COLW-1:0]                  r_s1_col;
    logic [ROWW-1:0]                  r_s1_row;
    logic                             r_s2_valid;
    logic                             r_s2_read;
    logic [AW-1:0]                    r_s2_addr;

    logic                             accept;
    logic                             gen_start;
    logic [XW-1:0]                    radius_eff;
    chva_pkg::t_gen_status            gen_status;
    logic [OW-1:0]                    gen_ofs_x;
    logic [OW-1:0]                    gen_ofs_y;
    logic                             p_valid;
    logic                             p_read;
    logic [OW-1:0]                    p_ofs_x;
    logic [OW-1:0]                    p_ofs_y;
    logic [CW-1:0]                    p_col;
    logic [CW-1:0]                    p_row;
    logic                             p_inside;
    logic [AW-1:0]                    s1_addr;
    logic                             ram_wr_en;
    logic [AW-1:0]                    ram_wr_addr;
    logic [chva_pkg::COUNT_W-1:0]     ram_wr_data;
    logic [chva_pkg::COUNT_W-1:0]     ram_rd_data;

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign gen_start  = accept && (i_in.kind == chva_pkg::KIND_VOTE);

    always_comb begin
        if (32'(r_radius) > MAX_RADIUS) begin
            radius_eff = XW'(MAX_RADIUS);
        end else begin
            radius_eff = XW'(r_radius);
        end
    end

    chva_circle_gen #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_gen (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (gen_start),
        .i_radius (radius_eff),
        .o_status (gen_status),
        .o_ofs_x  (gen_ofs_x),
        .o_ofs_y  (gen_ofs_y)
    );

    // Point stage: a circle point of a vote, or the cell of a read, is bounds-checked.
    always_comb begin
        p_read   = (r_state == S_READ);
        p_valid  = ((r_state == S_VOTE) && gen_status.pt_valid) || p_read;
        p_ofs_x  = p_read ? '0 : gen_ofs_x;
        p_ofs_y  = p_read ? '0 : gen_ofs_y;
        p_col    = CW'(r_px) + CW'(p_ofs_x);
        p_row    = CW'(r_py) + CW'(p_ofs_y);
        p_inside = (32'(p_col) < ACC_WIDTH) && (32'(p_row) < ACC_HEIGHT);
    end

    assign s1_addr = AW'(32'(r_s1_row) * ACC_WIDTH + 32'(r_s1_col));

    always_comb begin
        if (r_state == S_CLEAR) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = r_clr_addr;
            ram_wr_data = '0;
        end else begin
            ram_wr_en   = r_s2_valid && !r_s2_read;
            ram_wr_addr = r_s2_addr;
            ram_wr_data = ram_rd_data + chva_pkg::COUNT_W'(1);
        end
    end

    chva_ram #(
        .WIDTH (chva_pkg::COUNT_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (r_s1_valid),
        .i_rd_addr (s1_addr),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_radius    <= chva_pkg::RADIUS_RESET;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            o_out.valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_radius <= i_cfg_wr_data;
            end

            r_s1_valid <= p_valid && p_inside;
            r_s1_read  <= p_read;
            r_s1_col   <= COLW'(p_col);
            r_s1_row   <= ROWW'(p_row);
            r_s2_valid <= r_s1_valid;
            r_s2_read  <= r_s1_read;
            r_s2_addr  <= s1_addr;

            if (p_valid && !p_read) begin
                if (p_inside) begin
                    r_hits <= r_hits + chva_pkg::CAST_W'(1);
                end else begin
                    r_miss <= 1'b1;
                end
            end
            if (r_s2_valid && r_s2_read) begin
                r_cell <= ram_rd_data;
            end

            if (o_out.valid && o_out.ready && (r_state != S_DONE)) begin
                o_out.valid <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_px   <= i_in.pos_x;
                        r_py   <= i_in.pos_y;
                        r_hits <= '0;
                        r_miss <= 1'b0;
                        r_cell <= '0;
                        if (i_in.kind == chva_pkg::KIND_READ) begin
                            r_state <= S_READ;
                        end else begin
                            r_state <= S_VOTE;
                        end
                    end
                end
                S_VOTE: begin
                    if (!gen_status.busy) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_READ: begin
                    r_state <= S_DRAIN;
                end
                S_DRAIN: begin
                    if (!r_s1_valid && !r_s2_valid) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!o_out.valid || o_out.ready) begin
                        o_out.valid         <= 1'b1;
                        o_out.cell_count    <= r_cell;
                        o_out.votes_cast    <= r_hits;
                        o_out.votes_dropped <= r_miss;
                        r_state             <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_clear_no_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (!r_s1_valid && !r_s2_valid))
        else $error("vote pipeline active during store clear");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> (!r_s1_valid && !r_s2_valid && !gen_status.busy))
        else $error("input ready while an item is still in flight");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(r_state == S_DONE))
        else $error("result word raised outside the hand-off state");
`endif

endmodule

`default_nettype wire

// File: verif/circle_hough_vote_accumulator_tb.sv
// Self-checking testbench for circle_hough_vote_accumulator: votes and reads against a predictor.
// Depends on chva_pkg, chva_in_if, chva_out_if and the accumulator RTL.
// A queue-fed driver, a monitor and a scoreboard run in this one module.
module circle_hough_vote_accumulator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import chva_pkg::*;

    localparam int ACC_W       = ACC_WIDTH_DEF;
    localparam int ACC_H       = ACC_HEIGHT_DEF;
    localparam int MAX_R       = MAX_RADIUS_DEF;
    localparam int CYCLE_LIMIT = 6000000;

    typedef struct packed {
        logic               kind;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
    } t_request;

    typedef struct packed {
        logic [COUNT_W-1:0] cell_count;
        logic [CAST_W-1:0]  votes_cast;
        logic               votes_dropped;
    } t_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_wr_en;
    logic [RADIUS_W-1:0] i_cfg_wr_data;

    chva_in_if  in_ch();
    chva_out_if out_ch();

    circle_hough_vote_accumulator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_ch),
        .o_out         (out_ch)
    );

    bit [COUNT_W-1:0] vote_cells [ACC_W*ACC_H];
    t_request         pending_words[$];
    t_result          expected_results[$];
    int               radius_now = int'(RADIUS_RESET);
    int               errors = 0;
    int               results_seen = 0;
    int               cycle_count = 0;
    logic             in_taken = 1'b0;

    always #5 i_clk = ~i_clk;

    function automatic void vote_at(input int col, input int row,
                                    inout int hits, inout bit missed);
        if (col < 0 || row < 0 || col >= ACC_W || row >= ACC_H) begin
            missed = 1'b1;
        end else begin
            vote_cells[row*ACC_W + col] = vote_cells[row*ACC_W + col] + 1'b1;
            hits++;
        end
    endfunction

    function automatic void cast_circle(input int px, input int py, input int radius,
                                        output int hits, output bit missed);
        int r, cx, cy, x, y, err;
        r = (radius > MAX_R) ? MAX_R : radius;
        cx = px + r;
        cy = py + r;
        hits = 0;
        missed = 1'b0;
        x = r;
        y = 0;
        err = 1 - r;
        vote_at(cx + x, cy, hits, missed);
        if (r > 0) begin
            vote_at(cx, cy + x, hits, missed);
            vote_at(cx - x, cy, hits, missed);
            vote_at(cx, cy - x, hits, missed);
        end
        while (x > y) begin
            y++;
            if (err <= 0) begin
                err = err + 2*y + 1;
            end else begin
                x--;
                err = err + 2*y - 2*x + 1;
            end
            if (x < y) break;
            vote_at(cx + x, cy + y, hits, missed);
            vote_at(cx - x, cy + y, hits, missed);
            vote_at(cx + x, cy - y, hits, missed);
            vote_at(cx - x, cy - y, hits, missed);
            if (x != y) begin
                vote_at(cx + y, cy + x, hits, missed);
                vote_at(cx - y, cy + x, hits, missed);
                vote_at(cx + y, cy - x, hits, missed);
                vote_at(cx - y, cy - x, hits, missed);
            end
        end
    endfunction

    task automatic report_mismatch(input string msg);
        if (errors < 40) $display("mismatch at result %0d: %s", results_seen, msg);
        errors++;
    endtask

    task automatic push_word(input logic kind, input int x, input int y);
        t_request w;
        w.kind  = kind;
        w.pos_x = x[POS_W-1:0];
        w.pos_y = y[POS_W-1:0];
        pending_words = {pending_words, w};
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (pending_words.size() != 0 || in_ch.valid || expected_results.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_radius(input int r);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= r[RADIUS_W-1:0];
        radius_now = r & 7'h7F;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // Sender: bursts of words with random gaps, holding a word until it is taken.
    always @(negedge i_clk) begin : driver
        int burst_left, gap_left;
        t_request w;
        if (i_rst_n && (!in_ch.valid || in_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                w = pending_words.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.kind  <= w.kind;
                in_ch.pos_x <= w.pos_x;
                in_ch.pos_y <= w.pos_y;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: its own pattern of stalls, short flicker and long ready stretches.
    always @(negedge i_clk) begin : receiver
        int hold_left;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
        end else begin
            case ($urandom_range(0, 3))
                0: begin
                    out_ch.ready <= 1'b0;
                    hold_left = $urandom_range(1, 10);
                end
                1: begin
                    out_ch.ready <= 1'b1;
                    hold_left = $urandom_range(20, 60);
                end
                default: begin
                    out_ch.ready <= 1'($urandom_range(0, 1));
                    hold_left = $urandom_range(0, 3);
                end
            endcase
        end
    end

    always @(posedge i_clk) begin : monitor
        t_result got, want;
        int hits, px, py;
        bit missed;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("Simulation FAILED");
            $finish;
        end else if (i_rst_n) begin
            in_taken <= in_ch.valid && in_ch.ready;
            if (out_ch.valid && out_ch.ready) begin
                got.cell_count    = out_ch.cell_count;
                got.votes_cast    = out_ch.votes_cast;
                got.votes_dropped = out_ch.votes_dropped;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf(
                        "word with nothing expected: count %0d cast %0d drop %0b",
                        got.cell_count, got.votes_cast, got.votes_dropped));
                end else begin
                    want = expected_results.pop_front();
                    if (got.cell_count !== want.cell_count)
                        report_mismatch($sformatf("cell_count %0d, expected %0d",
                                                  got.cell_count, want.cell_count));
                    if (got.votes_cast !== want.votes_cast)
                        report_mismatch($sformatf("votes_cast %0d, expected %0d",
                                                  got.votes_cast, want.votes_cast));
                    if (got.votes_dropped !== want.votes_dropped)
                        report_mismatch($sformatf("votes_dropped %0b, expected %0b",
                                                  got.votes_dropped, want.votes_dropped));
                end
                results_seen++;
            end
            if (in_ch.valid && in_ch.ready) begin
                px = int'(in_ch.pos_x);
                py = int'(in_ch.pos_y);
                want = '0;
                if (in_ch.kind == KIND_READ) begin
                    if (px < ACC_W && py < ACC_H) want.cell_count = vote_cells[py*ACC_W + px];
                end else begin
                    cast_circle(px, py, radius_now, hits, missed);
                    want.votes_cast    = hits[CAST_W-1:0];
                    want.votes_dropped = missed;
                end
                expected_results = {expected_results, want};
            end
        end
    end

    initial begin : stimulus
        int phase_radius[10] = '{1, 5, 127, 0, 12, 64, 2, 38, 3, 20};
        int phase_items[10]  = '{250, 250, 80, 250, 250, 80, 250, 120, 250, 170};
        int clus_x[6], clus_y[6];
        int eff, vx, vy, col, row, k, dx, dy;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        in_ch.valid   = 1'b0;
        in_ch.kind    = KIND_VOTE;
        in_ch.pos_x   = '0;
        in_ch.pos_y   = '0;
        out_ch.ready  = 1'b1;
        for (int i = 0; i < 6; i++) begin
            clus_x[i] = $urandom_range(0, ACC_W - 1);
            clus_y[i] = $urandom_range(0, ACC_H - 1);
        end
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset radius, corner pixels, points pushed off the far edges.
        push_word(KIND_VOTE, 0, 0);
        push_word(KIND_VOTE, 511, 511);
        push_word(KIND_VOTE, 0, 511);
        push_word(KIND_VOTE, 511, 0);
        push_word(KIND_READ, 76, 38);
        push_word(KIND_READ, 38, 76);
        push_word(KIND_READ, 0, 38);
        push_word(KIND_READ, 511, 511);
        push_word(KIND_READ, 0, 0);
        drain();
        set_radius(0);
        push_word(KIND_VOTE, 0, 0);
        push_word(KIND_VOTE, 511, 511);
        push_word(KIND_VOTE, 0, 0);
        push_word(KIND_READ, 0, 0);
        push_word(KIND_READ, 511, 511);
        drain();
        set_radius(MAX_R);
        push_word(KIND_VOTE, 10, 20);
        push_word(KIND_VOTE, 447, 447);
        push_word(KIND_READ, 138, 84);
        drain();
        // A radius above the limit acts as the limit.
        set_radius(127);
        push_word(KIND_VOTE, 10, 20);
        push_word(KIND_READ, 138, 84);
        push_word(KIND_READ, 74, 148);
        drain();
        set_radius(1);
        push_word(KIND_VOTE, 5, 5);
        push_word(KIND_READ, 7, 6);
        push_word(KIND_READ, 6, 6);
        drain();

        for (int p = 0; p < 10; p++) begin
            set_radius(phase_radius[p]);
            eff = (phase_radius[p] > MAX_R) ? MAX_R : phase_radius[p];
            vx = clus_x[0];
            vy = clus_y[0];
            for (int i = 0; i < phase_items[p]; i++) begin
                if ($urandom_range(0, 99) < 65) begin
                    k = $urandom_range(0, 99);
                    if (k < 60) begin
                        k  = $urandom_range(0, 5);
                        vx = (clus_x[k] + $urandom_range(0, 6) - 3) & (ACC_W - 1);
                        vy = (clus_y[k] + $urandom_range(0, 6) - 3) & (ACC_H - 1);
                    end else if (k < 70) begin
                        vx = ($urandom_range(0, 1) == 1) ? ACC_W - 1 : 0;
                        vy = $urandom_range(0, ACC_H - 1);
                    end else begin
                        vx = $urandom_range(0, ACC_W - 1);
                        vy = $urandom_range(0, ACC_H - 1);
                    end
                    push_word(KIND_VOTE, vx, vy);
                end else begin
                    col = $urandom_range(0, ACC_W - 1);
                    row = $urandom_range(0, ACC_H - 1);
                    if ($urandom_range(0, 99) < 60) begin
                        case ($urandom_range(0, 3))
                            0: begin dx = eff;  dy = 0;    end
                            1: begin dx = 0;    dy = eff;  end
                            2: begin dx = -eff; dy = 0;    end
                            default: begin dx = 0; dy = -eff; end
                        endcase
                        if (vx + eff + dx < ACC_W && vy + eff + dy < ACC_H) begin
                            col = vx + eff + dx;
                            row = vy + eff + dy;
                        end
                    end
                    push_word(KIND_READ, col, row);
                end
            end
            drain();
        end

        repeat (500) @(negedge i_clk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
